[src/conv3x3_normalized_macros.svh]
// ---------------------------------------------------------------------------
// conv3x3_normalized assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled while
// rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef CONV3X3_NORMALIZED_MACROS_SVH
`define CONV3X3_NORMALIZED_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C3N_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C3N_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/c3n_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c3n_pkg
// Types and constants shared by the 3x3 convolution blocks.
// ---------------------------------------------------------------------------
package c3n_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned COL_SUM_W  = 26;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned MAG_W      = 27;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned HALF_SCALE_W = 12;
  localparam int unsigned PART_W     = MAG_W + HALF_SCALE_W;
  localparam int unsigned FULL_W     = MAG_W + SCALE_W;
  localparam int unsigned QUOT_W     = FULL_W - 16;
  localparam int unsigned VALUE_W    = 17;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned KROW_W     = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned TDATA_W    = 40;

  localparam int unsigned DIM_MIN    = 3;
  localparam int unsigned ROW_LIMIT  = 1024;
  localparam int unsigned VALUE_MAX  = 65535;
  localparam int unsigned ROUND_HALF = 32768;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4,
    CFG_NORM_SCALE    = 3'd5
  } cfg_index_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [2:0] coef_col_t;
  typedef logic [2:0][PIX_W-1:0] pix_col_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } meta_t;

endpackage

[src/c3n_line_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c3n_line_store
// One row of pixel storage with one write and one registered read port.
// ---------------------------------------------------------------------------
module c3n_line_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/c3n_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c3n_cell
// One column of the 3x3 window with its three products and column sum.
// ---------------------------------------------------------------------------
module c3n_cell (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        shift_i,
  input  c3n_pkg::pix_col_t                           col_i,
  input  c3n_pkg::coef_col_t                          coef_i,
  output c3n_pkg::pix_col_t                           col_o,
  output logic signed [c3n_pkg::COL_SUM_W-1:0]        sum_o
);
  import c3n_pkg::*;

  pix_col_t                    pix_q;
  logic signed [PROD_W-1:0]    prod_q [3];
  logic signed [PROD_W-1:0]    prod_d [3];
  logic signed [COL_SUM_W-1:0] sum_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_d[a] = PROD_W'($signed({1'b0, pix_q[a]}) * coef_i[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (en_i && shift_i) begin
      pix_q <= col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= prod_d[a];
      end
      sum_q <= COL_SUM_W'(prod_q[0]) + COL_SUM_W'(prod_q[1]) + COL_SUM_W'(prod_q[2]);
    end
  end

  assign col_o = pix_q;
  assign sum_o = sum_q;

endmodule

[src/c3n_normalize.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c3n_normalize
// Scales the window sum by the reciprocal, rounds off the low 16 bits to signed Q16.0 and saturates.
// ---------------------------------------------------------------------------
module c3n_normalize (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [c3n_pkg::SUM_W-1:0]      sum_i,
  input  logic [c3n_pkg::SCALE_W-1:0]           scale_i,
  output logic signed [c3n_pkg::VALUE_W-1:0]    value_o
);
  import c3n_pkg::*;

  logic signed [SUM_W-1:0]   neg_sum;
  logic [MAG_W-1:0]          mag_q;
  logic                      neg_q [3];
  logic [PART_W-1:0]         part_lo_q;
  logic [PART_W-1:0]         part_hi_q;
  logic [FULL_W-1:0]         full;
  logic [QUOT_W-1:0]         quot_q;
  logic [VALUE_W-1:0]        sat;
  logic signed [VALUE_W-1:0] value_q;

  assign neg_sum = -sum_i;

  always_comb begin
    full = FULL_W'(part_lo_q) + {part_hi_q, {HALF_SCALE_W{1'b0}}} + FULL_W'(ROUND_HALF);
    if (quot_q > QUOT_W'(VALUE_MAX)) begin
      sat = VALUE_W'(VALUE_MAX);
    end else begin
      sat = {1'b0, quot_q[VALUE_W-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= sum_i[SUM_W-1];
      mag_q     <= sum_i[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_i[MAG_W-1:0];
      neg_q[1]  <= neg_q[0];
      part_lo_q <= PART_W'(mag_q * scale_i[HALF_SCALE_W-1:0]);
      part_hi_q <= PART_W'(mag_q * scale_i[SCALE_W-1:HALF_SCALE_W]);
      neg_q[2]  <= neg_q[1];
      quot_q    <= full[FULL_W-1:16];
      value_q   <= neg_q[2] ? -$signed(sat) : $signed(sat);
    end
  end

  assign value_o = value_q;

endmodule

[src/conv3x3_normalized.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv3x3_normalized
// Normalized 3x3 convolution over a raster grey pixel stream.
// ---------------------------------------------------------------------------
// Throughput: one pixel per cycle, set by the single read port of each line
// store; a stalled output holds the whole pipeline.
// Reset: 640x480 frame, zero kernel and scale, counters and window cleared.
// The line stores are not cleared and hold no valid bits.
// ---------------------------------------------------------------------------
`include "conv3x3_normalized_macros.svh"

module conv3x3_normalized #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [c3n_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [c3n_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] pixel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [c3n_pkg::TDATA_W-1:0]      m_axis_tdata,   // [16:0] value,
                                                           // [26:17] out_row,
                                                           // [36:27] out_col
  output logic                             m_axis_tlast
);
  import c3n_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DEPTH = 9;

  logic [DIM_W-1:0]      image_width_q;
  logic [DIM_W-1:0]      image_height_q;
  logic [2:0][KROW_W-1:0] kernel_q;
  logic [SCALE_W-1:0]    norm_scale_q;

  logic [CW-1:0]         col_count_q;
  logic [ROW_W-1:0]      row_count_q;

  logic [WW-1:0]         w;
  logic [DIM_W-1:0]      h;
  logic [ROW_W-1:0]      r_base;
  logic [ROW_W-1:0]      r_cur;
  logic [ROW_W-1:0]      r_nxt;
  logic [CW-1:0]         c_cur;
  logic [CW-1:0]         c_nxt;
  logic [31:0]           r_tmp;
  logic [31:0]           c_tmp;
  logic [31:0]           row_m1;
  logic [31:0]           col_m1;
  logic [31:0]           h_m2;
  logic                  emit_cur;
  logic                  last_cur;

  logic                  en;
  logic                  s_fire;
  logic                  s1_valid_q;
  logic [PIX_W-1:0]      pix1_q;
  logic [CW-1:0]         ia1_q;
  logic [PIX_W-1:0]      rd_a;
  logic [PIX_W-1:0]      rd_b;

  meta_t                 meta_q [DEPTH];
  meta_t                 meta_in;

  pix_col_t              col_chain [1:3];
  coef_col_t             coef_cols [3];
  logic signed [COL_SUM_W-1:0] col_sum [3];
  logic signed [SUM_W-1:0] total_q;
  logic signed [VALUE_W-1:0] value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
      kernel_q       <= '0;
      norm_scale_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:   image_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  image_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_KERNEL_TOP:    kernel_q[0]    <= cfg_data_i[KROW_W-1:0];
        CFG_KERNEL_MIDDLE: kernel_q[1]    <= cfg_data_i[KROW_W-1:0];
        CFG_KERNEL_BOTTOM: kernel_q[2]    <= cfg_data_i[KROW_W-1:0];
        CFG_NORM_SCALE:    norm_scale_q   <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width_q) < DIM_MIN) begin
      w = WW'(DIM_MIN);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width_q);
    end
    if (32'(image_height_q) < DIM_MIN) begin
      h = DIM_W'(DIM_MIN);
    end else if (32'(image_height_q) > ROW_LIMIT) begin
      h = DIM_W'(ROW_LIMIT);
    end else begin
      h = image_height_q;
    end
  end

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    r_tmp  = '0;
    r_base = (32'(row_count_q) >= 32'(h)) ? '0 : row_count_q;
    if (32'(col_count_q) >= 32'(w)) begin
      c_cur = '0;
      r_tmp = 32'(r_base) + 32'd1;
      r_cur = (r_tmp >= 32'(h)) ? '0 : r_tmp[ROW_W-1:0];
    end else begin
      c_cur = col_count_q;
      r_cur = r_base;
    end
    c_tmp = 32'(c_cur) + 32'd1;
    if (c_tmp >= 32'(w)) begin
      c_nxt = '0;
      r_tmp = 32'(r_cur) + 32'd1;
      r_nxt = (r_tmp >= 32'(h)) ? '0 : r_tmp[ROW_W-1:0];
    end else begin
      c_nxt = c_tmp[CW-1:0];
      r_nxt = r_cur;
    end
    emit_cur = (r_cur >= ROW_W'(2)) && (32'(c_cur) >= 32'd2);
    last_cur = (32'(r_cur) == 32'(h) - 32'd1) && (32'(c_cur) == 32'(w) - 32'd1);
    row_m1   = 32'(r_cur) - 32'd1;
    col_m1   = 32'(c_cur) - 32'd1;
    h_m2     = 32'(h) - 32'd2;
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign s_fire        = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (s_fire) begin
      col_count_q <= c_nxt;
      row_count_q <= r_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      pix1_q <= s_axis_tdata;
      ia1_q  <= c_cur;
    end
  end

  c3n_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_store_above (
    .clk_i,
    .we_i    (en && s1_valid_q),
    .waddr_i (ia1_q),
    .wdata_i (pix1_q),
    .re_i    (en),
    .raddr_i (c_cur),
    .rdata_o (rd_a)
  );

  c3n_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_store_above2 (
    .clk_i,
    .we_i    (en && s1_valid_q),
    .waddr_i (ia1_q),
    .wdata_i (rd_a),
    .re_i    (en),
    .raddr_i (c_cur),
    .rdata_o (rd_b)
  );

  assign col_chain[3] = {pix1_q, rd_a, rd_b};

  // The kernel is flipped: window row a, column b meets coefficient (2-a, 2-b).
  for (genvar b = 0; b < 3; b++) begin : g_coef_col
    for (genvar a = 0; a < 3; a++) begin : g_coef_row
      assign coef_cols[b][a] = kernel_q[2-a][COEF_W*(2-b) +: COEF_W];
    end
  end

  c3n_cell u_cell2 (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .shift_i (s1_valid_q),
    .col_i   (col_chain[3]),
    .coef_i  (coef_cols[2]),
    .col_o   (col_chain[2]),
    .sum_o   (col_sum[2])
  );

  c3n_cell u_cell1 (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .shift_i (s1_valid_q),
    .col_i   (col_chain[2]),
    .coef_i  (coef_cols[1]),
    .col_o   (col_chain[1]),
    .sum_o   (col_sum[1])
  );

  c3n_cell u_cell0 (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .shift_i (s1_valid_q),
    .col_i   (col_chain[1]),
    .coef_i  (coef_cols[0]),
    .col_o   (),
    .sum_o   (col_sum[0])
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      total_q <= SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
    end
  end

  c3n_normalize u_normalize (
    .clk_i,
    .en_i    (en),
    .sum_i   (total_q),
    .scale_i (norm_scale_q),
    .value_o (value)
  );

  always_comb begin
    meta_in.valid = s_fire && emit_cur;
    meta_in.row   = row_m1[POS_W-1:0];
    meta_in.col   = col_m1[POS_W-1:0];
    meta_in.last  = last_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        meta_q[i] <= '0;
      end
    end else if (en) begin
      meta_q[0] <= meta_in;
      for (int i = 1; i < DEPTH; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  assign m_axis_tvalid = meta_q[DEPTH-1].valid;
  assign m_axis_tlast  = meta_q[DEPTH-1].last;
  assign m_axis_tdata  = {3'b000, meta_q[DEPTH-1].col, meta_q[DEPTH-1].row, value};

  `C3N_ASSERT_NOW(a_no_port_clash, s1_valid_q && s_fire, c_cur != ia1_q, "Line store read and write hit the same address.")
  `C3N_ASSERT_NOW(a_last_row, m_axis_tvalid && m_axis_tlast, meta_q[DEPTH-1].row == h_m2[POS_W-1:0], "Frame end flagged off the last interior row.")
  `C3N_ASSERT_NOW(a_value_range, m_axis_tvalid, value != $signed(17'h10000), "Result outside the saturation range.")
  `C3N_ASSERT_NEXT(a_frame_wrap, s_fire && last_cur, (col_count_q == '0) && (row_count_q == '0), "Counters did not wrap after the frame end.")

endmodule
